/* sv/brca_pkg.sv */
// Shared types and constants for the checked byte-addressed RAM.
package brca_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned CFG_W = 17;
  localparam int unsigned NUM_BANKS = 4;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_INVALID_STATE = 2'd1,
    ST_INVALID_WIDTH = 2'd2,
    ST_OUT_OF_BOUNDS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CTRL_RUN   = 2'b01,
    CTRL_SWEEP = 2'b10
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic sweep_en;
    logic sweep_load;
  } cmd_t;

  typedef struct packed {
    logic clear_go;
    logic sweep_last;
  } stat_t;

endpackage

/* sv/byte_ram_checked_access_unit.sv */
// Top level of the checked byte-addressed RAM.
//
// Requests: a transfer happens at a clock edge with start high and busy low.
// operation selects read, write or clear; byte_offset and access_width give
// a 1, 2 or 4 byte little-endian access at any offset.
// Results: done_o marks status_o and read_data_o for one cycle; the request
// goes through a first register stage and then the output registers, and
// the receiver always takes the results. Reads and writes transfer one per
// cycle while busy is low: the store is four byte-wide banks, each with its
// own row address, so any unaligned access touches each bank at most once.
// A clear that passes its check holds busy while the bank rows in use are
// zeroed, one row per cycle.
// After reset the store is zeroed the same way: busy stays high while all
// MEM_BYTES bytes are zeroed. The size register resets to zero.
// Size writes: cfg_valid_i with the value; cfg_ready_o is always high.
module byte_ram_checked_access_unit #(
  parameter int unsigned MEM_BYTES = brca_pkg::MEM_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 operation_i,
  input  logic [31:0]                byte_offset_i,
  input  logic [2:0]                 access_width_i,
  input  logic [31:0]                write_data_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [brca_pkg::CFG_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [31:0]                read_data_o
);

  brca_pkg::cmd_t  cmd;
  brca_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  brca_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  brca_datapath #(
    .MEM_BYTES(MEM_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .operation_i   (operation_i),
    .byte_offset_i (byte_offset_i),
    .access_width_i(access_width_i),
    .write_data_i  (write_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .read_data_o   (read_data_o)
  );

endmodule

/* sv/brca_ram.sv */
// Generic single-port RAM with registered read data.
module brca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/brca_ctrl.sv */
// Controller: request acceptance and store sweep sequencing.
module brca_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  brca_pkg::stat_t stat_i,
  output brca_pkg::cmd_t  cmd_o
);

  brca_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    cmd_o.accept     = start_i && (state_q == brca_pkg::CTRL_RUN);
    cmd_o.sweep_en   = (state_q == brca_pkg::CTRL_SWEEP);
    cmd_o.sweep_load = cmd_o.accept && stat_i.clear_go;
    state_d = state_q;
    unique case (state_q)
      brca_pkg::CTRL_RUN: begin
        if (cmd_o.sweep_load) begin
          state_d = brca_pkg::CTRL_SWEEP;
        end
      end
      brca_pkg::CTRL_SWEEP: begin
        if (stat_i.sweep_last) begin
          state_d = brca_pkg::CTRL_RUN;
        end
      end
      default: state_d = brca_pkg::CTRL_SWEEP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brca_pkg::CTRL_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == brca_pkg::CTRL_SWEEP);

endmodule

/* sv/brca_datapath.sv */
// Datapath: size register, request checks, four byte banks, read assembly.
module brca_datapath #(
  parameter int unsigned MEM_BYTES = brca_pkg::MEM_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [brca_pkg::CFG_W-1:0] cfg_data_i,
  input  logic [1:0]                 operation_i,
  input  logic [31:0]                byte_offset_i,
  input  logic [2:0]                 access_width_i,
  input  logic [31:0]                write_data_i,
  input  brca_pkg::cmd_t             cmd_i,
  output brca_pkg::stat_t            stat_o,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [31:0]                read_data_o
);

  localparam int unsigned BANK_DEPTH = (MEM_BYTES + 3) / 4;
  localparam int unsigned RW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(MEM_BYTES + 1);
  localparam int unsigned CW = RW + 3;
  localparam logic [32:0] LIM = 33'(MEM_BYTES);

  logic [brca_pkg::CFG_W-1:0] mem_size_q;
  logic [32:0]                size_use;
  logic [32:0]                end_addr;
  brca_pkg::status_e          chk;
  brca_pkg::status_e          st;
  logic                       is_read;
  logic                       is_write;
  logic                       is_clear;
  logic                       ok;
  logic [RW-1:0]              row_lo;
  logic [1:0]                 lane0;

  logic [RW-1:0]              sweep_row_q;
  logic [LW-1:0]              limit_q;

  logic [7:0]                 bank_rd [brca_pkg::NUM_BANKS];

  logic                       v1_q;
  brca_pkg::status_e          st1_q;
  logic                       rd1_q;
  logic [1:0]                 off1_q;
  logic [2:0]                 w1_q;
  logic [31:0]                asm_data;

  logic                       done_q;
  logic [1:0]                 status_q;
  logic [31:0]                rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= '0;
    end else if (cfg_valid_i) begin
      mem_size_q <= cfg_data_i;
    end
  end

  assign size_use = (33'(mem_size_q) > LIM) ? LIM : 33'(mem_size_q);
  assign end_addr = {1'b0, byte_offset_i} + 33'(access_width_i);

  always_comb begin
    if (size_use == '0) begin
      chk = brca_pkg::ST_INVALID_STATE;
    end else if (!(access_width_i == 3'd1 || access_width_i == 3'd2 ||
                   access_width_i == 3'd4)) begin
      chk = brca_pkg::ST_INVALID_WIDTH;
    end else if (end_addr > size_use) begin
      chk = brca_pkg::ST_OUT_OF_BOUNDS;
    end else begin
      chk = brca_pkg::ST_OK;
    end
  end

  always_comb begin
    is_read  = 1'b0;
    is_write = 1'b0;
    is_clear = 1'b0;
    st       = brca_pkg::ST_OK;
    unique case (brca_pkg::op_e'(operation_i))
      brca_pkg::OP_READ: begin
        is_read = 1'b1;
        st      = chk;
      end
      brca_pkg::OP_WRITE: begin
        is_write = 1'b1;
        st       = chk;
      end
      brca_pkg::OP_CLEAR: begin
        is_clear = 1'b1;
        st = (size_use == '0) ? brca_pkg::ST_INVALID_STATE : brca_pkg::ST_OK;
      end
      default: st = brca_pkg::ST_OK;
    endcase
  end

  assign ok     = (st == brca_pkg::ST_OK);
  assign row_lo = byte_offset_i[2 +: RW];
  assign lane0  = byte_offset_i[1:0];

  assign stat_o.clear_go   = is_clear && ok;
  assign stat_o.sweep_last = (CW'({sweep_row_q, 2'b00}) + CW'(4)) >= CW'(limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_row_q <= '0;
      limit_q     <= LW'(MEM_BYTES);
    end else if (cmd_i.sweep_load) begin
      sweep_row_q <= '0;
      limit_q     <= LW'(size_use);
    end else if (cmd_i.sweep_en) begin
      sweep_row_q <= sweep_row_q + RW'(1);
    end
  end

  for (genvar b = 0; b < brca_pkg::NUM_BANKS; b++) begin : g_bank
    logic [1:0]    lane;
    logic [RW-1:0] row;
    logic          we_acc;
    logic          we;
    logic [RW-1:0] addr;
    logic [7:0]    wdata;

    assign lane   = 2'(b) - lane0;
    assign row    = row_lo + RW'(2'(b) < lane0);
    assign we_acc = cmd_i.accept && is_write && ok && ({1'b0, lane} < access_width_i);

    always_comb begin
      if (cmd_i.sweep_en) begin
        addr  = sweep_row_q;
        we    = CW'({sweep_row_q, 2'(b)}) < CW'(limit_q);
        wdata = '0;
      end else begin
        addr  = row;
        we    = we_acc;
        wdata = write_data_i[{lane, 3'b000} +: 8];
      end
    end

    brca_ram #(
      .WIDTH(8),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .addr_i (addr),
      .wdata_i(wdata),
      .rdata_o(bank_rd[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.accept;
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q  <= st;
    rd1_q  <= is_read && ok;
    off1_q <= lane0;
    w1_q   <= access_width_i;
  end

  always_comb begin
    asm_data = '0;
    for (int k = 0; k < 4; k++) begin
      if (rd1_q && (3'(k) < w1_q)) begin
        asm_data[8*k +: 8] = bank_rd[off1_q + 2'(k)];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= st1_q;
    rdata_q  <= asm_data;
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign read_data_o = rdata_q;

endmodule
